/* rtl/wcmp_pkg.sv */
// Shared constants, types and reset table for the walk count matrix power block.
package wcmp_pkg;

  // Graph size and index widths
  localparam int unsigned NODES       = 8;
  localparam int unsigned NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned ADJ_W       = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned LENGTH_BITS = 31;

  // Matrix store: two banks of NODES x NODES entries
  localparam int unsigned ADDR_W    = 2 * NODE_W + 1;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;

  // Modular arithmetic widths
  localparam int unsigned VAL_W  = 30;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned HI_W   = VAL_W + 1;
  localparam int unsigned EST_W  = 2 * HI_W;
  localparam int unsigned LO_W   = VAL_W + 2;

  localparam logic [VAL_W-1:0] MODULUS     = 30'd1000000007;
  localparam logic [VAL_W-1:0] ONE_MOD     = 30'd1;
  localparam logic [VAL_W:0]   MOD_SUM     = {1'b0, MODULUS};
  localparam logic [LO_W-1:0]  MOD_LO      = {2'b00, MODULUS};
  localparam logic [LO_W-1:0]  TWO_MOD_LO  = {1'b0, MODULUS, 1'b0};

  // Barrett reciprocal floor(2^PROD_W / MODULUS), worked out at elaboration
  localparam logic [63:0]     BARRETT_M64 = (64'd1 << PROD_W) / {34'd0, MODULUS};
  localparam logic [HI_W-1:0] BARRETT_M   = BARRETT_M64[HI_W-1:0];

  // Operation tag that travels with each multiply-accumulate
  typedef struct packed {
    logic              vec_op;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] dst;
  } wcmp_tag_t;

  // Finished dot product from the shared unit
  typedef struct packed {
    logic              valid;
    logic              vec_op;
    logic [ADDR_W-1:0] dst;
  } wcmp_res_t;

  // Neighbour masks after reset
  function automatic logic [ADJ_W-1:0] adj_reset(int unsigned idx);
    logic [ADJ_W-1:0] val;
    case (idx)
      0:       val = 8'd6;
      1:       val = 8'd13;
      2:       val = 8'd27;
      3:       val = 8'd54;
      4:       val = 8'd172;
      5:       val = 8'd88;
      6:       val = 8'd160;
      7:       val = 8'd80;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/wcmp_mac.sv */
// Pipelined modular multiply-accumulate unit with Barrett reduction.
module wcmp_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_valid_i,
  input  wcmp_pkg::wcmp_tag_t           op_tag_i,
  input  logic [wcmp_pkg::VAL_W-1:0]    op_a_i,
  input  logic [wcmp_pkg::VAL_W-1:0]    op_b_i,
  output wcmp_pkg::wcmp_res_t           res_o,
  output logic [wcmp_pkg::VAL_W-1:0]    res_value_o,
  output logic                          busy_o
);

  logic [3:0]                       vld_q;
  wcmp_pkg::wcmp_tag_t              tag1_q, tag2_q, tag3_q, tag4_q;
  logic                             res_vld_q;
  logic                             res_vec_q;
  logic [wcmp_pkg::ADDR_W-1:0]      res_dst_q;

  logic [wcmp_pkg::PROD_W-1:0]      prod_d, prod_q;
  logic [wcmp_pkg::HI_W-1:0]        prod_hi;
  logic [wcmp_pkg::EST_W-1:0]       est_d, est_q;
  logic [wcmp_pkg::LO_W-1:0]        xlo2_q, xlo3_q;
  logic [wcmp_pkg::VAL_W-1:0]       quot;
  logic [wcmp_pkg::PROD_W-1:0]      qp_full;
  logic [wcmp_pkg::LO_W-1:0]        qp_lo_q;
  logic [wcmp_pkg::LO_W-1:0]        rem_raw, rem_fix;
  logic [wcmp_pkg::VAL_W-1:0]       rem4_q;
  logic [wcmp_pkg::VAL_W-1:0]       acc_base;
  logic [wcmp_pkg::VAL_W:0]         acc_sum, acc_fix;
  logic [wcmp_pkg::VAL_W-1:0]       acc_q;

  // Advance the valid bits and tags through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[2:0], op_valid_i};
      res_vld_q <= vld_q[3] & tag4_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q    <= op_tag_i;
    tag2_q    <= tag1_q;
    tag3_q    <= tag2_q;
    tag4_q    <= tag3_q;
    res_vec_q <= tag4_q.vec_op;
    res_dst_q <= tag4_q.dst;
  end

  // Stage 1: full product
  assign prod_d = op_a_i * op_b_i;

  // Stage 2: quotient estimate from the top bits times the reciprocal
  assign prod_hi = prod_q[wcmp_pkg::PROD_W-1:wcmp_pkg::VAL_W-1];
  assign est_d   = prod_hi * wcmp_pkg::BARRETT_M;

  // Stage 3: quotient times modulus, low bits only
  assign quot    = est_q[2*wcmp_pkg::VAL_W:wcmp_pkg::HI_W];
  assign qp_full = quot * wcmp_pkg::MODULUS;

  // Stage 4: remainder below three moduli, fold into range
  always_comb begin
    rem_raw = xlo3_q - qp_lo_q;
    if (rem_raw >= wcmp_pkg::TWO_MOD_LO) begin
      rem_fix = rem_raw - wcmp_pkg::TWO_MOD_LO;
    end else if (rem_raw >= wcmp_pkg::MOD_LO) begin
      rem_fix = rem_raw - wcmp_pkg::MOD_LO;
    end else begin
      rem_fix = rem_raw;
    end
  end

  // Stage 5: modular accumulate, restart on the first term of a dot product
  always_comb begin
    acc_base = tag4_q.first ? '0 : acc_q;
    acc_sum  = {1'b0, acc_base} + {1'b0, rem4_q};
    acc_fix  = (acc_sum >= wcmp_pkg::MOD_SUM) ? (acc_sum - wcmp_pkg::MOD_SUM) : acc_sum;
  end

  // Hold the datapath registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    est_q   <= est_d;
    xlo2_q  <= prod_q[wcmp_pkg::LO_W-1:0];
    qp_lo_q <= qp_full[wcmp_pkg::LO_W-1:0];
    xlo3_q  <= xlo2_q;
    rem4_q  <= rem_fix[wcmp_pkg::VAL_W-1:0];
    if (vld_q[3]) begin
      acc_q <= acc_fix[wcmp_pkg::VAL_W-1:0];
    end
  end

  assign res_o.valid  = res_vld_q;
  assign res_o.vec_op = res_vec_q;
  assign res_o.dst    = res_dst_q;
  assign res_value_o  = acc_q;
  assign busy_o       = (|vld_q) | res_vld_q;

`ifndef SYNTHESIS
  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_value_o < wcmp_pkg::MODULUS))
    else $error("accumulated value not reduced");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (rem4_q < wcmp_pkg::MODULUS))
    else $error("Barrett remainder not reduced");

  a_res_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> $past(vld_q[3]))
    else $error("result without a term in the last stage");
`endif

endmodule

/* rtl/walk_count_matrix_power.sv */
// Top level: closed-walk counter with sequencer, matrix store and vector registers.
//
// Returns the number of walks of walk_length_i steps from node 0 back to node 0
// of the graph held in the eight adjacency mask registers, modulo 1000000007.
// One item runs square-and-multiply on a single pipelined modular
// multiply-accumulate unit that takes one term per cycle: a load of the
// adjacency matrix, then for each bit of the length a vector product of 64 terms
// when the bit is set and a matrix squaring of 512 terms while higher bits
// remain, each followed by a pipeline drain. A length of 0 returns 1.
// in_ready_o is high only between items; the result waits in an output register.
module walk_count_matrix_power (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wcmp_pkg::LENGTH_BITS-1:0]   walk_length_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wcmp_pkg::VAL_W-1:0]         walk_total_o,
  input  logic                               cfg_we_i,
  input  logic [wcmp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wcmp_pkg::ADJ_W-1:0]         cfg_data_i
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_LOAD   = 9'b000000010,
    ST_TEST   = 9'b000000100,
    ST_VMUL   = 9'b000001000,
    ST_VDRAIN = 9'b000010000,
    ST_STEP   = 9'b000100000,
    ST_SQR    = 9'b001000000,
    ST_SDRAIN = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  localparam logic [wcmp_pkg::NODE_W-1:0] NodeLast = wcmp_pkg::NODE_W'(wcmp_pkg::NODES - 1);

  state_e                                state_q, state_d;
  logic [wcmp_pkg::ADJ_W-1:0]            adj_q [wcmp_pkg::NODES];
  logic [wcmp_pkg::LENGTH_BITS-1:0]      len_q, len_d;
  logic [wcmp_pkg::NODE_W-1:0]           cnt_r_q, cnt_r_d;
  logic [wcmp_pkg::NODE_W-1:0]           cnt_c_q, cnt_c_d;
  logic [wcmp_pkg::NODE_W-1:0]           cnt_k_q, cnt_k_d;
  logic                                  msel_q, msel_d;
  logic                                  vsel_q, vsel_d;
  logic                                  out_valid_q;
  logic [wcmp_pkg::VAL_W-1:0]            walk_total_q;

  logic [wcmp_pkg::VAL_W-1:0]            mat_mem [wcmp_pkg::MEM_DEPTH];
  logic [wcmp_pkg::VAL_W-1:0]            vec_q [2][wcmp_pkg::NODES];

  logic                                  issue_valid;
  wcmp_pkg::wcmp_tag_t                   issue_tag;
  logic [wcmp_pkg::ADDR_W-1:0]           addr_a, addr_b;
  logic                                  rd_valid_q;
  wcmp_pkg::wcmp_tag_t                   rd_tag_q;
  logic [wcmp_pkg::VAL_W-1:0]            rd_a_q, rd_b_q, vec_rd_q;
  logic [wcmp_pkg::VAL_W-1:0]            mac_a;

  wcmp_pkg::wcmp_res_t                   mac_res;
  logic [wcmp_pkg::VAL_W-1:0]            mac_value;
  logic                                  mac_busy;
  logic                                  busy;

  logic                                  in_xfer;
  logic                                  out_load;
  logic [wcmp_pkg::ADJ_W-1:0]            ld_shift;
  logic                                  mem_we;
  logic [wcmp_pkg::ADDR_W-1:0]           mem_waddr;
  logic [wcmp_pkg::VAL_W-1:0]            mem_wdata;
  logic                                  cfg_hit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign busy        = rd_valid_q | mac_busy;
  assign out_load    = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);

  // Configuration writes; indexes beyond the register list are dropped
  assign cfg_hit = cfg_we_i
                 && ({1'b0, cfg_idx_i} < (wcmp_pkg::CFG_IDX_W + 1)'(wcmp_pkg::REG_COUNT))
                 && ({1'b0, cfg_idx_i} < (wcmp_pkg::CFG_IDX_W + 1)'(wcmp_pkg::NODES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wcmp_pkg::NODES; i++) begin
        adj_q[i] <= wcmp_pkg::adj_reset(i);
      end
    end else if (cfg_hit) begin
      adj_q[cfg_idx_i[wcmp_pkg::NODE_W-1:0]] <= cfg_data_i;
    end
  end

  // Sequencer: load, then per length bit an optional vector product and a squaring
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cnt_r_d = cnt_r_q;
    cnt_c_d = cnt_c_q;
    cnt_k_d = cnt_k_q;
    msel_d  = msel_q;
    vsel_d  = vsel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          len_d   = walk_length_i;
          cnt_r_d = '0;
          cnt_c_d = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_c_d = cnt_c_q + 1'b1;
        if (cnt_c_q == NodeLast) begin
          cnt_c_d = '0;
          cnt_r_d = cnt_r_q + 1'b1;
          if (cnt_r_q == NodeLast) begin
            cnt_r_d = '0;
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        cnt_r_d = '0;
        cnt_c_d = '0;
        cnt_k_d = '0;
        if (len_q == '0) begin
          state_d = ST_DONE;
        end else if (len_q[0]) begin
          state_d = ST_VMUL;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_VMUL: begin
        cnt_k_d = cnt_k_q + 1'b1;
        if (cnt_k_q == NodeLast) begin
          cnt_k_d = '0;
          cnt_c_d = cnt_c_q + 1'b1;
          if (cnt_c_q == NodeLast) begin
            cnt_c_d = '0;
            state_d = ST_VDRAIN;
          end
        end
      end
      ST_VDRAIN: begin
        if (!busy) begin
          vsel_d  = ~vsel_q;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        len_d   = len_q >> 1;
        cnt_r_d = '0;
        cnt_c_d = '0;
        cnt_k_d = '0;
        if ((len_q >> 1) != '0) begin
          state_d = ST_SQR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SQR: begin
        cnt_k_d = cnt_k_q + 1'b1;
        if (cnt_k_q == NodeLast) begin
          cnt_k_d = '0;
          cnt_c_d = cnt_c_q + 1'b1;
          if (cnt_c_q == NodeLast) begin
            cnt_c_d = '0;
            cnt_r_d = cnt_r_q + 1'b1;
            if (cnt_r_q == NodeLast) begin
              cnt_r_d = '0;
              state_d = ST_SDRAIN;
            end
          end
        end
      end
      ST_SDRAIN: begin
        if (!busy) begin
          msel_d  = ~msel_q;
          state_d = ST_TEST;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cnt_r_q <= '0;
      cnt_c_q <= '0;
      cnt_k_q <= '0;
      msel_q  <= 1'b0;
      vsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_r_q <= cnt_r_d;
      cnt_c_q <= cnt_c_d;
      cnt_k_q <= cnt_k_d;
      msel_q  <= msel_d;
      vsel_q  <= vsel_d;
    end
  end

  // Issue one term per cycle: addresses and tag for the shared unit
  always_comb begin
    issue_valid      = (state_q == ST_SQR) | (state_q == ST_VMUL);
    issue_tag.vec_op = (state_q == ST_VMUL);
    issue_tag.first  = (cnt_k_q == '0);
    issue_tag.last   = (cnt_k_q == NodeLast);
    addr_a           = {msel_q, cnt_r_q, cnt_k_q};
    addr_b           = {msel_q, cnt_k_q, cnt_c_q};
    if (state_q == ST_VMUL) begin
      issue_tag.dst = wcmp_pkg::ADDR_W'(cnt_c_q);
    end else begin
      issue_tag.dst = {~msel_q, cnt_r_q, cnt_c_q};
    end
  end

  // Register the operand reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= issue_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= issue_tag;
    rd_a_q   <= mat_mem[addr_a];
    rd_b_q   <= mat_mem[addr_b];
    vec_rd_q <= vec_q[vsel_q][cnt_k_q];
  end

  assign mac_a = rd_tag_q.vec_op ? vec_rd_q : rd_a_q;

  wcmp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (rd_valid_q),
    .op_tag_i    (rd_tag_q),
    .op_a_i      (mac_a),
    .op_b_i      (rd_b_q),
    .res_o       (mac_res),
    .res_value_o (mac_value),
    .busy_o      (mac_busy)
  );

  // Matrix store write: adjacency load sweep or a finished squaring entry
  assign ld_shift = adj_q[cnt_r_q] >> cnt_c_q;

  always_comb begin
    if (state_q == ST_LOAD) begin
      mem_we    = 1'b1;
      mem_waddr = {msel_q, cnt_r_q, cnt_c_q};
      mem_wdata = {{(wcmp_pkg::VAL_W - 1){1'b0}}, ld_shift[0]};
    end else begin
      mem_we    = mac_res.valid & ~mac_res.vec_op;
      mem_waddr = mac_res.dst;
      mem_wdata = mac_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mat_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Row vector banks: unit vector on transfer, products into the other bank
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < wcmp_pkg::NODES; i++) begin
        vec_q[vsel_q][i] <= (i == 0) ? wcmp_pkg::ONE_MOD : '0;
      end
    end else if (mac_res.valid && mac_res.vec_op) begin
      vec_q[~vsel_q][mac_res.dst[wcmp_pkg::NODE_W-1:0]] <= mac_value;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      walk_total_q <= vec_q[vsel_q][0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign walk_total_o = walk_total_q;

`ifndef SYNTHESIS
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !busy)
    else $error("ready while terms are still in flight");

  a_total_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (walk_total_o < wcmp_pkg::MODULUS))
    else $error("walk total not reduced");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !mac_res.valid)
    else $error("result arrives during the adjacency load");
`endif

endmodule

/* tb/sv/walk_count_checker.sv */
// Checker for the walk count block: predicts every closed-walk total and compares results.
module walk_count_checker
  import wcmp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [LENGTH_BITS-1:0] walk_length_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [VAL_W-1:0]       walk_total_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ADJ_W-1:0]       cfg_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o
);

  localparam longint unsigned PRIME = 64'(MODULUS);

  // Neighbour masks after reset, node 0 in the low byte
  localparam logic [NODES*ADJ_W-1:0] ADJ_AFTER_RESET =
    {8'd80, 8'd160, 8'd88, 8'd172, 8'd54, 8'd27, 8'd13, 8'd6};

  logic [ADJ_W-1:0] adj_rows [NODES];
  logic [VAL_W-1:0] expected_totals [$];
  logic [VAL_W-1:0] oldest_total;
  int unsigned      mismatches = 0;
  int unsigned      totals_seen = 0;

  assign fail_count_o = mismatches;
  assign checked_o    = totals_seen;

  // Print one line per failure and count it
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] walk total check: %s", $time, what);
  endtask

  // Square-and-multiply over the current adjacency, all sums reduced mod the prime
  function automatic longint unsigned count_closed_walks(input logic [LENGTH_BITS-1:0] steps);
    longint unsigned        walk_mat [NODES][NODES];
    longint unsigned        sq_mat [NODES][NODES];
    longint unsigned        reach [NODES];
    longint unsigned        reach_next [NODES];
    longint unsigned        acc;
    logic [LENGTH_BITS-1:0] rest;
    int                     r, c, k;
    rest = steps;
    for (r = 0; r < NODES; r++) begin
      for (c = 0; c < NODES; c++) begin
        walk_mat[r][c] = adj_rows[r][c];
      end
      reach[r] = (r == 0) ? 1 : 0;
    end
    while (rest != 0) begin
      // Take one more power into the row vector for each set bit
      if (rest[0]) begin
        for (c = 0; c < NODES; c++) begin
          acc = 0;
          for (k = 0; k < NODES; k++) begin
            acc = (acc + (reach[k] * walk_mat[k][c]) % PRIME) % PRIME;
          end
          reach_next[c] = acc;
        end
        for (c = 0; c < NODES; c++) begin
          reach[c] = reach_next[c];
        end
      end
      rest = rest >> 1;
      // Square only while higher bits remain
      if (rest != 0) begin
        for (r = 0; r < NODES; r++) begin
          for (c = 0; c < NODES; c++) begin
            acc = 0;
            for (k = 0; k < NODES; k++) begin
              acc = (acc + (walk_mat[r][k] * walk_mat[k][c]) % PRIME) % PRIME;
            end
            sq_mat[r][c] = acc;
          end
        end
        for (r = 0; r < NODES; r++) begin
          for (c = 0; c < NODES; c++) begin
            walk_mat[r][c] = sq_mat[r][c];
          end
        end
      end
    end
    return reach[0];
  endfunction

  // Track register writes, predict on each input transfer, compare on each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        adj_rows[i] = ADJ_AFTER_RESET[i*ADJ_W +: ADJ_W];
      end
      expected_totals.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < REG_COUNT && cfg_idx_i < NODES) begin
        adj_rows[cfg_idx_i] = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_totals.push_back(VAL_W'(count_closed_walks(walk_length_i)));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_totals.size() == 0) begin
          report_mismatch($sformatf("total %0d with no length outstanding", walk_total_i));
        end else begin
          oldest_total = expected_totals.pop_front();
          totals_seen++;
          if (walk_total_i !== oldest_total) begin
            report_mismatch($sformatf("walk_total %0d, predicted %0d",
                                      walk_total_i, oldest_total));
          end
        end
      end
      pending_o <= expected_totals.size();
    end
  end

endmodule

/* tb/sv/walk_count_matrix_power_tb.sv */
// Testbench top for the walk count block: clock, reset, stimulus, back-pressure and verdict.
module walk_count_matrix_power_tb;
  import wcmp_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned PHASE_ITEMS  = 15;
  localparam longint      RUN_LIMIT    = 120_000_000;

  localparam logic [NODES*ADJ_W-1:0] NO_EDGES  = '0;
  localparam logic [NODES*ADJ_W-1:0] ALL_EDGES = '1;
  // One-way ring 0 -> 1 -> ... -> 7 -> 0
  localparam logic [NODES*ADJ_W-1:0] RING_MAP =
    {8'h01, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02};

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_RARELY
  } stall_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic [LENGTH_BITS-1:0] walk_length_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [VAL_W-1:0]       walk_total_o;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [ADJ_W-1:0]       cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent  = 0;
  int unsigned maps_loaded = 0;
  int unsigned burst_left  = 0;
  bit          gapless     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  walk_count_matrix_power DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .walk_length_i (walk_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .walk_total_o  (walk_total_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  walk_count_checker u_walk_count_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .walk_length_i (walk_length_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .walk_total_i  (walk_total_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Mostly short lengths, some zero, a few spanning all 31 bits
  function automatic logic [LENGTH_BITS-1:0] pick_length();
    int unsigned roll;
    int unsigned bits;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return LENGTH_BITS'($urandom());
    end
    if (roll < 13) begin
      return '0;
    end
    bits = $urandom_range(1, 10);
    return LENGTH_BITS'($urandom() & ((32'd1 << bits) - 1));
  endfunction

  // Random masks, either as written (one-way edges) or mirrored into an undirected graph
  function automatic logic [NODES*ADJ_W-1:0] random_map(input bit mirrored);
    logic [NODES*ADJ_W-1:0] map;
    bit                     edge_bit;
    map = {$urandom(), $urandom()};
    if (mirrored) begin
      for (int r = 0; r < NODES; r++) begin
        for (int c = r + 1; c < NODES; c++) begin
          edge_bit = $urandom_range(0, 1);
          map[r*ADJ_W + c] = edge_bit;
          map[c*ADJ_W + r] = edge_bit;
        end
      end
    end
    return map;
  endfunction

  // Offer one length and hold it until the transfer
  task automatic offer_length(input logic [LENGTH_BITS-1:0] len);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    walk_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Send in bursts with idle gaps between them, unless the phase runs gapless
  task automatic send_length(input logic [LENGTH_BITS-1:0] len);
    if (burst_left == 0) begin
      if (!gapless) begin
        repeat ($urandom_range(1, 12)) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    offer_length(len);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted total has come back
  task automatic drain_totals();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_adj(input logic [CFG_IDX_W-1:0] idx, input logic [ADJ_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  // Load all rows, then one write to an index past the last row, which must be ignored
  task automatic load_map(input logic [NODES*ADJ_W-1:0] map);
    for (int i = 0; i < NODES; i++) begin
      write_adj(CFG_IDX_W'(i), map[i*ADJ_W +: ADJ_W]);
    end
    write_adj(CFG_IDX_W'($urandom_range(NODES, 2**CFG_IDX_W - 1)), ADJ_W'($urandom()));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    maps_loaded++;
  endtask

  // Receiver: random stall stretches, plus one long hold-off on request
  initial begin : receiver
    int unsigned stretch;
    int unsigned held;
    stall_mode_e mode;
    forever begin
      if (hold_req && !hold_done) begin
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        stretch = $urandom_range(1, 40);
        mode    = stall_mode_e'($urandom_range(0, 3));
        repeat (stretch) begin
          @(negedge clk_i);
          case (mode)
            READY_ALWAYS: out_ready_i <= 1'b1;
            READY_COIN:   out_ready_i <= $urandom_range(0, 1);
            READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
            default:      out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [LENGTH_BITS-1:0] reset_map_lengths [12];
    reset_map_lengths = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6,
                          31'h7FFFFFFF, 31'h40000000, 31'h55555555, 31'h2AAAAAAA,
                          31'h12345678};
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Fixed map from reset: zero length, short walks and every length bit in both states
    foreach (reset_map_lengths[i]) begin
      send_length(reset_map_lengths[i]);
    end

    // Complete graph with self-loops
    drain_totals();
    load_map(ALL_EDGES);
    send_length(31'd0);
    send_length(31'd1);
    send_length(31'd2);
    send_length(31'h7FFFFFFF);

    // Empty graph: only the zero-length walk exists
    drain_totals();
    load_map(NO_EDGES);
    send_length(31'd0);
    send_length(31'd1);
    send_length(31'h7FFFFFFF);

    // One-way ring: closed walks only at multiples of eight
    drain_totals();
    load_map(RING_MAP);
    send_length(31'd7);
    send_length(31'd8);
    send_length(31'd16);
    send_length(31'h7FFFFFF8);

    // Random graphs, alternately one-way and mirrored
    for (int phase = 0; phase < 5; phase++) begin
      drain_totals();
      load_map(random_map(phase[0]));
      gapless = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Hold the output off while short lengths keep coming, so the input stalls
        gapless  = 1'b1;
        hold_req = 1'b1;
        repeat (6) send_length(LENGTH_BITS'($urandom_range(0, 1)));
        gapless  = 1'b0;
      end
      repeat (PHASE_ITEMS) send_length(pick_length());
    end

    drain_totals();
    $display("Run covered %0d walk lengths over %0d adjacency settings", items_sent, maps_loaded);
    $display("(empty, complete, ring and random graphs); %0d totals compared, %0d failed.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
